// ----- hdl/feistel_block_cipher_64_macros.svh -----
// Assertion macros shared by the cipher RTL.
`ifndef FEISTEL_BLOCK_CIPHER_64_MACROS_SVH
`define FEISTEL_BLOCK_CIPHER_64_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge while reset is low.
`define FBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FBC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FBC_ASSERT(label, clk, rst, prop, msg)
`define FBC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- hdl/fbc_pkg.sv -----
// Shared constants and rotate helpers for the Feistel block cipher.
package fbc_pkg;

  localparam int BLOCK_W        = 64;
  localparam int HALF_W         = 32;
  localparam int KEY_W          = 64;
  localparam int ROUNDS_DEFAULT = 8;
  localparam int MIX_ROTL       = 9;
  localparam int KEY_ROTR       = 11;
  localparam int KEY_STEP       = 3;

  function automatic logic [HALF_W-1:0] rotl32(input logic [HALF_W-1:0] v, input int n);
    int s;
    s = n % HALF_W;
    return (v << s) | (v >> (HALF_W - s));
  endfunction

  function automatic logic [HALF_W-1:0] rotr32(input logic [HALF_W-1:0] v, input int n);
    int s;
    s = n % HALF_W;
    return (v >> s) | (v << (HALF_W - s));
  endfunction

  function automatic logic [KEY_W-1:0] rotr64(input logic [KEY_W-1:0] v, input int n);
    int s;
    s = n % KEY_W;
    return (v >> s) | (v << (KEY_W - s));
  endfunction

endpackage

// ----- hdl/fbc_round.sv -----
// One Feistel round: mixing function and half swap.
module fbc_round #(
  parameter bit LAST_ROUND = 1'b0
) (
  input  logic [fbc_pkg::HALF_W-1:0] left_in,
  input  logic [fbc_pkg::HALF_W-1:0] right_in,
  input  logic [fbc_pkg::HALF_W-1:0] subkey,
  output logic [fbc_pkg::HALF_W-1:0] left_out,
  output logic [fbc_pkg::HALF_W-1:0] right_out
);

  logic [fbc_pkg::HALF_W-1:0] mix;
  logic [fbc_pkg::HALF_W-1:0] t;

  assign mix = fbc_pkg::rotl32(left_in, fbc_pkg::MIX_ROTL)
             ^ ~fbc_pkg::rotr32(subkey, fbc_pkg::KEY_ROTR)
             ^ left_in;
  assign t = right_in ^ mix;

  // The final round keeps the left half in place instead of swapping.
  generate
    if (LAST_ROUND) begin : g_last
      assign left_out  = left_in;
      assign right_out = t;
    end else begin : g_mid
      assign left_out  = t;
      assign right_out = left_in;
    end
  endgenerate

endmodule

// ----- hdl/feistel_block_cipher_64.sv -----
// Top level of the 64-bit Feistel block cipher.
// This block enciphers (action = 0) or deciphers (action = 1) one 64-bit block per beat with a
// Feistel network of ROUNDS rounds (8 by default); the upper half of a block is the left part.
// Round i uses the low 32 bits of secret_key rotated right by 3*i bits, and decryption walks
// the same subkeys in reverse order, so it undoes encryption. An accepted beat is captured in
// an input register, all rounds are evaluated in one pass of XOR and fixed-rotate logic, and
// the result lands in an output register. out_valid rises when the beat moves from the input
// register into the output register, which it does once that register is free, and the
// block sustains one beat per clock as long as out_ready keeps up. The
// round logic depth grows linearly with ROUNDS and sets the clock period. The key is loaded
// through cfg_wr_en / cfg_wr_data, takes effect on the next cycle, and must only be changed
// while no beat is in flight. The key resets to zero.
`include "feistel_block_cipher_64_macros.svh"

module feistel_block_cipher_64 #(
  parameter int ROUNDS = fbc_pkg::ROUNDS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // Key load.
  input  logic                        cfg_wr_en,
  input  logic [fbc_pkg::KEY_W-1:0]   cfg_wr_data,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [fbc_pkg::BLOCK_W-1:0] data_block,
  // Output channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fbc_pkg::BLOCK_W-1:0] result_block
);

  localparam int HW = fbc_pkg::HALF_W;

  // Master key register, the only configuration state.
  logic [fbc_pkg::KEY_W-1:0] secret_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      secret_key <= '0;
    end else if (cfg_wr_en) begin
      secret_key <= cfg_wr_data;
    end
  end

  // Input register. The valid bit is control state; the payload needs no reset.
  logic                        s1_valid;
  logic                        s1_action;
  logic [fbc_pkg::BLOCK_W-1:0] s1_data;
  logic                        s1_advance;
  logic                        out_free;

  // The output register can take a new beat when it is empty or being drained this cycle.
  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_data   <= data_block;
    end
  end

  // Subkeys are pure wiring of the key: a fixed rotate and a slice per round.
  logic [HW-1:0] round_key [ROUNDS];

  genvar g;
  generate
    for (g = 0; g < ROUNDS; g++) begin : g_key
      localparam int KEY_ROT = (g * fbc_pkg::KEY_STEP) % fbc_pkg::KEY_W;
      logic [fbc_pkg::KEY_W-1:0] rotated;
      assign rotated      = fbc_pkg::rotr64(secret_key, KEY_ROT);
      assign round_key[g] = rotated[HW-1:0];
    end
  endgenerate

  // Round chain. Each stage of the chain picks its subkey from either end of the key
  // schedule depending on the direction of the beat held in the input register.
  logic [HW-1:0] l_chain [ROUNDS+1];
  logic [HW-1:0] r_chain [ROUNDS+1];

  assign l_chain[0] = s1_data[fbc_pkg::BLOCK_W-1:HW];
  assign r_chain[0] = s1_data[HW-1:0];

  generate
    for (g = 0; g < ROUNDS; g++) begin : g_round
      logic [HW-1:0] subkey;
      assign subkey = s1_action ? round_key[ROUNDS-1-g] : round_key[g];

      fbc_round #(
        .LAST_ROUND(g == ROUNDS - 1)
      ) u_round (
        .left_in  (l_chain[g]),
        .right_in (r_chain[g]),
        .subkey   (subkey),
        .left_out (l_chain[g+1]),
        .right_out(r_chain[g+1])
      );
    end
  endgenerate

  logic [fbc_pkg::BLOCK_W-1:0] cipher_out;
  assign cipher_out = {l_chain[ROUNDS], r_chain[ROUNDS]};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result_block <= cipher_out;
    end
  end

  // A beat held in the input register while the output is blocked must not be disturbed.
  `FBC_ASSERT(a_s1_hold, clk, rst,
              s1_valid && !out_free |=> s1_valid && $stable(s1_data) && $stable(s1_action),
              "input register changed while stalled")
  // Every accepted beat is captured in the input register.
  `FBC_ASSERT(a_s1_capture, clk, rst,
              in_valid && in_ready |=> s1_valid && s1_data == $past(data_block),
              "accepted beat not captured")
  // A beat moving forward shows up at the output with the value computed from it.
  `FBC_ASSERT(a_out_load, clk, rst,
              s1_advance |=> out_valid && result_block == $past(cipher_out),
              "result register not loaded")
  // A key write takes effect on the following cycle.
  `FBC_ASSERT(a_key_load, clk, rst,
              cfg_wr_en |=> secret_key == $past(cfg_wr_data),
              "key write lost")
  // Nothing is valid right after reset.
  `FBC_ASSERT_ALWAYS(a_reset_empty, clk,
                     $past(rst) |-> !s1_valid && !out_valid,
                     "pipeline not empty after reset")

endmodule

// ----- dv/feistel_block_cipher_64_checker.sv -----
// Checker for the Feistel block cipher: tracks the key, predicts each result and compares.
module feistel_block_cipher_64_checker #(
  parameter int ROUNDS = fbc_pkg::ROUNDS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [fbc_pkg::KEY_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        action,
  input  logic [fbc_pkg::BLOCK_W-1:0] data_block,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [fbc_pkg::BLOCK_W-1:0] result_block,
  output int                          mismatch_count,
  output int                          blocks_pending,
  output int                          blocks_checked
);

  typedef struct {
    logic                        decrypt;
    logic [fbc_pkg::BLOCK_W-1:0] plain;
    logic [fbc_pkg::BLOCK_W-1:0] cipher;
  } cipher_job_t;

  cipher_job_t                 expected_blocks[$];
  logic [fbc_pkg::KEY_W-1:0]   key_copy = '0;
  int                          errors   = 0;
  int                          checked  = 0;

  function automatic logic [31:0] rot_left32(logic [31:0] v, int n);
    int s;
    s = n & 31;
    if (s == 0) return v;
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] rot_right32(logic [31:0] v, int n);
    int s;
    s = n & 31;
    if (s == 0) return v;
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [63:0] rot_right64(logic [63:0] v, int n);
    int s;
    s = n & 63;
    if (s == 0) return v;
    return (v >> s) | (v << (64 - s));
  endfunction

  // Runs the whole network; decryption walks the subkeys from the last round down.
  function automatic logic [63:0] feistel_transform(logic decrypt, logic [63:0] blk,
                                                    logic [63:0] key);
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] subkey;
    logic [31:0] t;
    logic [63:0] rotated;
    int          rnd;
    left  = blk[63:32];
    right = blk[31:0];
    for (int step = 0; step < ROUNDS; step++) begin
      rnd     = decrypt ? (ROUNDS - 1 - step) : step;
      rotated = rot_right64(key, fbc_pkg::KEY_STEP * rnd);
      subkey  = rotated[31:0];
      t = right ^ (rot_left32(left, fbc_pkg::MIX_ROTL) ^
                   ~rot_right32(subkey, fbc_pkg::KEY_ROTR) ^ left);
      if (step < ROUNDS - 1) begin
        right = left;
        left  = t;
      end else begin
        right = t;
      end
    end
    return {left, right};
  endfunction

  always @(posedge clk) begin
    cipher_job_t job;
    if (rst) begin
      key_copy = '0;
      expected_blocks.delete();
    end else begin
      // Results are checked before new beats are queued; latency keeps them apart.
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result beat %h with nothing outstanding",
                     $realtime, result_block);
        end else begin
          job = expected_blocks.pop_front();
          checked++;
          if (result_block !== job.cipher) begin
            errors++;
            if (errors <= 10)
              $display("[%0t] mismatch: action=%0b in=%h expected %h got %h", $realtime,
                       job.decrypt, job.plain, job.cipher, result_block);
          end
        end
      end
      if (in_valid && in_ready) begin
        job.decrypt = action;
        job.plain   = data_block;
        job.cipher  = feistel_transform(action, data_block, key_copy);
        expected_blocks.insert(expected_blocks.size(), job);
      end
      if (cfg_wr_en) key_copy = cfg_wr_data;
    end
    mismatch_count <= errors;
    blocks_pending <= expected_blocks.size();
    blocks_checked <= checked;
  end

endmodule

// ----- dv/feistel_block_cipher_64_test.sv -----
// Top of the cipher testbench: clock, reset, stimulus, back-pressure and the final verdict.
module feistel_block_cipher_64_test;

  // A quiet stretch of this many cycles with no beat on either channel means a hang.
  // The longest legal quiet stretch is the deliberate output hold-off below.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 100;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                        clk;
  logic                        rst         = 1'b1;
  logic                        cfg_wr_en   = 1'b0;
  logic [fbc_pkg::KEY_W-1:0]   cfg_wr_data = '0;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  logic                        action      = 1'b0;
  logic [fbc_pkg::BLOCK_W-1:0] data_block  = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  logic [fbc_pkg::BLOCK_W-1:0] result_block;

  int mismatch_count;
  int blocks_pending;
  int blocks_checked;

  // Idle percentages for the two sides; the stimulus changes them between phases.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request = 1'b0;

  int blocks_sent   = 0;
  int encrypt_count = 0;
  int decrypt_count = 0;
  int keys_loaded   = 0;

  feistel_block_cipher_64 u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .data_block   (data_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_block (result_block)
  );

  feistel_block_cipher_64_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .data_block     (data_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_block   (result_block),
    .mismatch_count (mismatch_count),
    .blocks_pending (blocks_pending),
    .blocks_checked (blocks_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Outside a hold-off the receiver decides out_ready once per cycle. A hold-off request
  // keeps it low for a long stretch, counted here, so the pipeline fills and input stalls.
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // The watchdog ends the run if neither channel moves a beat for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timed out after %0d cycles with no beat, %0d results outstanding.",
             WATCHDOG_LIMIT, blocks_pending);
    $display("== FAIL ==");
    $finish;
  end

  task automatic apply_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        tx_idle_pct  = 79;
        rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 79;
      end
      default: begin
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
      end
    endcase
  endtask

  // Offers one beat and returns at the edge where it is accepted. Valid is only lowered
  // during a sender gap, so back-to-back beats keep it high without a glitch.
  task automatic send_block(input logic act, input logic [fbc_pkg::BLOCK_W-1:0] blk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    data_block <= blk;
    do @(posedge clk); while (!in_ready);
    blocks_sent++;
    if (act) decrypt_count++;
    else encrypt_count++;
  endtask

  // Drops valid and waits until every expected result has come back, then lets the pipeline
  // settle before anything else touches the key. The first wait lets the pending count catch
  // up with the beat accepted at the current edge.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blocks_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_key(input logic [fbc_pkg::KEY_W-1:0] key);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= key;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    keys_loaded++;
  endtask

  // One random phase under a fixed key. Most blocks are fully random; about one in four
  // is a corner pattern so the extremes keep showing up under every key.
  task automatic run_key_phase(input logic [fbc_pkg::KEY_W-1:0] key, input idle_mode_t mode,
                               input bit long_hold);
    logic [fbc_pkg::BLOCK_W-1:0] blk;
    load_key(key);
    apply_idle_mode(mode);
    if (long_hold) hold_request = 1'b1;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      case ($urandom_range(0, 15))
        0: blk = '0;
        1: blk = '1;
        2: blk = {32'h0000_0000, $urandom()};
        3: blk = {$urandom(), 32'h0000_0000};
        default: blk = {$urandom(), $urandom()};
      endcase
      send_block(1'($urandom_range(0, 1)), blk);
    end
    drain_pipeline();
  endtask

  initial begin
    logic [fbc_pkg::BLOCK_W-1:0] corner_blocks[8];
    corner_blocks = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                      64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
                      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset key of zero: every corner block in both directions,
    // with no idling so beats go back to back.
    apply_idle_mode(IDLE_NONE);
    for (int d = 0; d < 2; d++) begin
      for (int c = 0; c < 8; c++) send_block(d[0], corner_blocks[c]);
    end
    drain_pipeline();

    // Random phases: each key setting runs under one idle pattern. The all-ones key and an
    // explicitly written zero key cover the extremes; the last phase also asks for the long
    // output hold-off while the sender keeps offering beats.
    run_key_phase('1, IDLE_NONE, 1'b0);
    run_key_phase({$urandom(), $urandom()}, IDLE_SENDER, 1'b0);
    run_key_phase(64'h8000_0000_0000_0001, IDLE_RECEIVER, 1'b0);
    run_key_phase({$urandom(), $urandom()}, IDLE_BOTH, 1'b0);
    run_key_phase('0, IDLE_NONE, 1'b1);

    // Nothing is outstanding now; keep the clock running so any stray beat still shows up.
    repeat (10) @(posedge clk);

    $display("Covered %0d blocks (%0d encrypt, %0d decrypt), reset key plus %0d loaded keys,",
             blocks_sent, encrypt_count, decrypt_count, keys_loaded);
    $display("four idle patterns, one long output hold-off; %0d checked, %0d mismatches.",
             blocks_checked, mismatch_count);
    if (mismatch_count == 0 && blocks_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
